// ----- src/sfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // frame marker bytes
  localparam logic [7:0] HDR_FIRST  = 8'h2C;
  localparam logic [7:0] HDR_SECOND = 8'h12;
  localparam logic [7:0] FRAME_TAIL = 8'h5B;

  // payload lengths per format
  localparam logic [2:0] LEN_FMT0 = 3'd4;
  localparam logic [2:0] LEN_FMT1 = 3'd1;

  // payload store depth
  localparam int unsigned PAYLOAD_DEPTH = 4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_FORMAT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECEIVE_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] first_value;
    logic [7:0]  second_value;
    logic [7:0]  third_value;
  } result_t;

endpackage

`default_nettype wire

// ----- src/sfd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser (
  input  wire              clk,
  input  wire              rst,
  input  wire              step,
  input  wire  [7:0]       rx_byte,
  input  wire              frame_format,
  output logic             res_valid,
  output sfd_pkg::result_t res
);
  import sfd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [2:0] count_inc;
  logic [2:0] need;
  logic [7:0] payload [PAYLOAD_DEPTH];

  assign count_inc = count + 3'd1;
  assign need      = frame_format ? LEN_FMT1 : LEN_FMT0;

  // next phase and payload count
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (step) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HDR_FIRST) begin
            phase_next = PH_HDR2;
            count_next = 3'd0;
          end
        end
        PH_HDR2: begin
          phase_next = (rx_byte == HDR_SECOND) ? PH_DATA : PH_HUNT;
        end
        PH_DATA: begin
          count_next = count_inc;
          if (count_inc >= need) begin
            phase_next = PH_TAIL;
          end
        end
        PH_TAIL: begin
          phase_next = PH_HUNT;
          count_next = 3'd0;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // result decode on a matching tail
  always_comb begin
    res_valid = step && (phase == PH_TAIL) && (rx_byte == FRAME_TAIL);
    if (frame_format) begin
      res.first_value  = {8'h00, payload[0]};
      res.second_value = 8'h00;
      res.third_value  = 8'h00;
    end else begin
      res.first_value  = {payload[0], payload[1]};
      res.second_value = payload[2];
      res.third_value  = payload[3];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      count <= 3'd0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk) begin
    if (step && (phase == PH_DATA)) begin
      payload[count[1:0]] <= rx_byte;
    end
  end

  a_hdr2_count_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HDR2) |-> (count == 3'd0))
    else $error("count not cleared on header start");

  a_data_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (count < LEN_FMT0))
    else $error("payload count overran store in data phase");

  a_tail_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAIL) |-> ((count != 3'd0) && (count <= LEN_FMT0)))
    else $error("tail phase with bad payload count");

endmodule

`default_nettype wire

// ----- src/sfd_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_buf (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  sfd_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  wire              out_ready,
  output sfd_pkg::result_t out_data
);
  import sfd_pkg::*;

  result_t    entry [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[head];

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
    end
  end

  // result entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("output buffer count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full output buffer");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (head == tail))
    else $error("output buffer pointers out of step with count");

endmodule

`default_nettype wire

// ----- src/serial_frame_deframer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// a tail byte's result is decoded combinationally and written into the output buffer, which drives out_valid
// throughput: one byte per cycle; in_ready drops only while the two-entry
//   output buffer holds two results that have not been taken
// reset (rst, synchronous): parser back to header hunt, output buffer empty,
//   frame_format 0, receive_enable 1; payload store is not cleared
module serial_frame_deframer_core (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [7:0]                     rx_byte,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [15:0]                    first_value,
  output logic [7:0]                     second_value,
  output logic [7:0]                     third_value,
  input  wire                            cfg_write,
  input  wire  [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [0:0]                     cfg_data
);
  import sfd_pkg::*;

  logic    frame_format;
  logic    receive_enable;
  logic    buf_full;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format   <= 1'b0;
      receive_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_FORMAT:   frame_format   <= cfg_data[0];
        CFG_RECEIVE_ENABLE: receive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a byte is parsed on each input transfer while receive is enabled
  assign in_ready = !buf_full;
  assign step     = in_valid && in_ready && receive_enable;

  sfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (rx_byte),
    .frame_format (frame_format),
    .res_valid    (res_valid),
    .res          (res)
  );

  sfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign first_value  = out_data.first_value;
  assign second_value = out_data.second_value;
  assign third_value  = out_data.third_value;

endmodule

`default_nettype wire
